>>> sv/tgp_pkg.sv
// Shared types, codes and helpers of the touch gesture to pointer block.
package tgp_pkg;

   localparam int NORM_W   = 16;
   localparam int SIZE_W   = 13;
   localparam int COORD_W  = 12;
   localparam int ID_W     = 8;
   localparam int TIME_W   = 32;
   localparam int TAP_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_RESULTS = 3;
   localparam int RCNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int RPOS_W   = $clog2(MAX_RESULTS);

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_TIME      = 2'd2;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;
   localparam logic [TAP_W-1:0]  RESET_TAP    = 16'd250;

   localparam logic BTN_LEFT  = 1'b0;
   localparam logic BTN_RIGHT = 1'b1;

   typedef enum logic [1:0] {
      ACT_DOWN   = 2'd0,
      ACT_UP     = 2'd1,
      ACT_MOTION = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      EV_MOVE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   typedef enum logic [1:0] {
      DRAG_IDLE  = 2'd0,
      DRAG_TWO   = 2'd1,
      DRAG_THREE = 2'd2,
      DRAG_SPENT = 2'd3
   } drag_mode_type;

   typedef struct packed {
      event_kind_type      kind;
      logic                button;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
   } result_type;

   typedef struct packed {
      logic [RCNT_W-1:0]               count;
      result_type [MAX_RESULTS-1:0]    res;
   } batch_type;

   // True when time t has reached or passed time u, modulo 2^32.
   function automatic logic ticks_passed(input logic [TIME_W-1:0] t,
                                         input logic [TIME_W-1:0] u);
      logic [TIME_W-1:0] d;
      d = u - t;
      return (d == '0) || d[TIME_W-1];
   endfunction

endpackage

>>> sv/tgp_scale.sv
// Fixed-point scaling of a normalized touch coordinate to screen pixels.
module tgp_scale
   import tgp_pkg::*;
(
   input  logic [NORM_W-1:0]  norm,
   input  logic [SIZE_W-1:0]  size,
   output logic [COORD_W-1:0] pos
);

   logic [NORM_W+SIZE_W-1:0] prod;
   logic [SIZE_W-1:0]        whole;

   assign prod  = norm * size;
   assign whole = prod[NORM_W+SIZE_W-1:NORM_W];
   // saturate anything past the 12-bit screen range
   assign pos   = (whole > SIZE_W'(2 ** COORD_W - 1)) ? '1 : whole[COORD_W-1:0];

endmodule

>>> sv/tgp_gesture.sv
// Finger slot table, drag mode and gesture decisions for one event.
module tgp_gesture
   import tgp_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [1:0]          action,
   input  logic [ID_W-1:0]     finger_id,
   input  logic [TIME_W-1:0]   now,
   input  logic [COORD_W-1:0]  pos_x,
   input  logic [COORD_W-1:0]  pos_y,
   input  logic [TAP_W-1:0]    tap_time,
   output batch_type           batch
);

   localparam int SIW = $clog2(SLOTS);
   localparam int DCW = $clog2(SLOTS + 1);

   logic [SLOTS-1:0]   used_ff, used_in;
   logic [ID_W-1:0]    sid_ff    [SLOTS];
   logic [ID_W-1:0]    sid_in    [SLOTS];
   logic [TIME_W-1:0]  dt_ff     [SLOTS];
   logic [TIME_W-1:0]  dt_in     [SLOTS];
   logic [COORD_W-1:0] fx_ff     [SLOTS];
   logic [COORD_W-1:0] fx_in     [SLOTS];
   logic [COORD_W-1:0] fy_ff     [SLOTS];
   logic [COORD_W-1:0] fy_in     [SLOTS];
   logic [COORD_W-1:0] lx_ff     [SLOTS];
   logic [COORD_W-1:0] lx_in     [SLOTS];
   logic [COORD_W-1:0] ly_ff     [SLOTS];
   logic [COORD_W-1:0] ly_in     [SLOTS];
   drag_mode_type      mode_ff, mode_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in;

   logic [SLOTS-1:0]   match;
   logic [SLOTS-1:0]   held_long;
   logic [DCW-1:0]     down;
   logic [DCW-1:0]     longs;
   logic               hit;
   logic [SIW-1:0]     idx;
   logic               take_hit;
   logic [SIW-1:0]     take_idx;
   logic               early_found;
   logic [SIW-1:0]     first;
   logic [TIME_W-1:0]  early;
   logic               drag_start;
   logic               changed;
   logic               moves;
   logic               drag_btn;

   // Per-slot match and long-hold tests.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i]     = used_ff[i] && (sid_ff[i] == finger_id);
         held_long[i] = used_ff[i] &&
                        ticks_passed(now, dt_ff[i] + TIME_W'(tap_time));
      end
      down  = DCW'($countones(used_ff));
      longs = DCW'($countones(held_long));
   end

   // Highest matching slot for up/motion, lowest free-or-matching for down.
   always_comb begin
      hit      = 1'b0;
      idx      = '0;
      take_hit = 1'b0;
      take_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match[i]) begin
            hit = 1'b1;
            idx = SIW'(i);
         end
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i] || match[i]) begin
            take_hit = 1'b1;
            take_idx = SIW'(i);
         end
      end
   end

   // Earliest finger, scanned in slot order with the wrapping compare.
   always_comb begin
      early_found = 1'b0;
      first       = '0;
      early       = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (used_ff[i] && (!early_found || !ticks_passed(dt_ff[i], early))) begin
            early_found = 1'b1;
            first       = SIW'(i);
            early       = dt_ff[i];
         end
      end
   end

   assign drag_start = (down >= DCW'(2)) && (mode_ff == DRAG_IDLE) && (longs >= DCW'(2));
   assign drag_btn   = (longs == DCW'(2)) ? BTN_LEFT : BTN_RIGHT;
   assign changed    = (pos_x != lx_ff[idx]) || (pos_y != ly_ff[idx]);
   assign moves      = (down <= DCW'(1)) || (first == idx);

   // Decide results and next state.
   always_comb begin
      used_in = used_ff;
      sid_in  = sid_ff;
      dt_in   = dt_ff;
      fx_in   = fx_ff;
      fy_in   = fy_ff;
      lx_in   = lx_ff;
      ly_in   = ly_ff;
      mode_in = mode_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      batch   = '0;

      case (action)
         ACT_DOWN: begin
            if (take_hit) begin
               used_in[take_idx] = 1'b1;
               sid_in[take_idx]  = finger_id;
               dt_in[take_idx]   = now;
               fx_in[take_idx]   = pos_x;
               fy_in[take_idx]   = pos_y;
               lx_in[take_idx]   = pos_x;
               ly_in[take_idx]   = pos_y;
               mode_in           = DRAG_IDLE;
               if (down == '0) begin
                  batch.res[0] = '{kind: EV_MOVE, button: BTN_LEFT, x: pos_x, y: pos_y};
                  batch.count  = RCNT_W'(1);
                  px_in        = pos_x;
                  py_in        = pos_y;
               end
            end
         end
         ACT_UP: begin
            if (hit) begin
               used_in[idx] = 1'b0;
               if (mode_ff == DRAG_IDLE) begin
                  // tap: one finger gives left, two fingers give right
                  if (!held_long[idx] && (down <= DCW'(2))) begin
                     if (down == DCW'(2))
                        mode_in = DRAG_SPENT;
                     batch.res[0] = '{kind: EV_MOVE, button: BTN_LEFT, x: pos_x, y: pos_y};
                     batch.res[1] = '{kind: EV_PRESS, button: (down == DCW'(2)),
                                      x: pos_x, y: pos_y};
                     batch.res[2] = '{kind: EV_RELEASE, button: (down == DCW'(2)),
                                      x: pos_x, y: pos_y};
                     batch.count  = RCNT_W'(3);
                     px_in        = pos_x;
                     py_in        = pos_y;
                  end
               end else if (down == DCW'(1)) begin
                  // last finger lifted: end the drag at the pointer
                  mode_in = DRAG_IDLE;
                  if ((mode_ff == DRAG_TWO) || (mode_ff == DRAG_THREE)) begin
                     batch.res[0] = '{kind: EV_MOVE, button: BTN_LEFT, x: px_ff, y: py_ff};
                     batch.res[1] = '{kind: EV_RELEASE,
                                      button: (mode_ff == DRAG_THREE),
                                      x: px_ff, y: py_ff};
                     batch.count  = RCNT_W'(2);
                  end
               end
            end
         end
         ACT_MOTION: begin
            if (hit) begin
               if (drag_start) begin
                  mode_in      = (longs == DCW'(2)) ? DRAG_TWO : DRAG_THREE;
                  batch.res[0] = '{kind: EV_MOVE, button: BTN_LEFT,
                                   x: fx_ff[first], y: fy_ff[first]};
                  batch.res[1] = '{kind: EV_PRESS, button: drag_btn,
                                   x: fx_ff[first], y: fy_ff[first]};
                  batch.count  = RCNT_W'(2);
                  px_in        = fx_ff[first];
                  py_in        = fy_ff[first];
               end
               if (changed) begin
                  lx_in[idx] = pos_x;
                  ly_in[idx] = pos_y;
                  if (moves) begin
                     if (drag_start) begin
                        batch.res[2] = '{kind: EV_MOVE, button: BTN_LEFT, x: pos_x, y: pos_y};
                        batch.count  = RCNT_W'(3);
                     end else begin
                        batch.res[0] = '{kind: EV_MOVE, button: BTN_LEFT, x: pos_x, y: pos_y};
                        batch.count  = RCNT_W'(1);
                     end
                     px_in = pos_x;
                     py_in = pos_y;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         mode_ff <= DRAG_IDLE;
         px_ff   <= '0;
         py_ff   <= '0;
      end else if (fire) begin
         used_ff <= used_in;
         mode_ff <= mode_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
      end
   end

   // Slot payload: only read while the slot is in use.
   always_ff @(posedge clock) begin
      if (fire) begin
         sid_ff <= sid_in;
         dt_ff  <= dt_in;
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         lx_ff  <= lx_in;
         ly_ff  <= ly_in;
      end
   end

endmodule

>>> sv/tgp_outq.sv
// Result register: holds one event's results and sends them one per cycle while rsp_ready is high.
module tgp_outq
   import tgp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  batch_type           batch,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_event_kind,
   output logic                rsp_button,
   output logic [COORD_W-1:0]  rsp_out_x,
   output logic [COORD_W-1:0]  rsp_out_y,
   output logic                rsp_last
);

   logic [RCNT_W-1:0]             cnt_ff;
   logic [RPOS_W-1:0]             pos_ff;
   result_type [MAX_RESULTS-1:0]  res_ff;
   result_type                    head;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_last  = (cnt_ff == RCNT_W'(1));
   assign load_ok   = !rsp_valid || (rsp_last && rsp_ready);
   assign head      = res_ff[pos_ff];

   assign rsp_event_kind = head.kind;
   assign rsp_button     = head.button;
   assign rsp_out_x      = head.x;
   assign rsp_out_y      = head.y;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else if (load) begin
         cnt_ff <= batch.count;
         pos_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         cnt_ff <= cnt_ff - RCNT_W'(1);
         pos_ff <= pos_ff + RPOS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= batch.res;
      end
   end

endmodule

>>> sv/touch_gesture_to_pointer.sv
// Top level of the touch gesture to pointer translator.
//
// Turns finger down/up/motion transactions from a touch panel into pointer
// move, button press and button release transactions. Each accepted request
// is scaled to screen pixels as it enters the input register
// ((norm * size) >> 16, saturated to 4095), then evaluated combinationally
// against the finger slot table and drag mode, which load the result register
// with zero to three results. Results leave one per cycle while rsp_ready is
// high, in order, with rsp_last marking the final result of a request. With
// the result register free, a request passes the input register and then the
// result register before its first result is valid; one request per cycle is
// taken when each yields at most one result and the receiver does not stall.
// A request with several results holds the result register until its last
// result is taken. The result register drains in parallel with the next
// request waiting in the input register. Tracks FINGER_SLOTS fingers
// (2 to 8). Configuration writes (screen width, screen height, tap time) take
// effect at once and belong only to idle periods.
module touch_gesture_to_pointer
   import tgp_pkg::*;
#(
   parameter int FINGER_SLOTS = 3
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_action,
   input  logic [ID_W-1:0]        req_finger_id,
   input  logic [TIME_W-1:0]      req_timestamp_ms,
   input  logic [NORM_W-1:0]      req_norm_x,
   input  logic [NORM_W-1:0]      req_norm_y,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_event_kind,
   output logic                   rsp_button,
   output logic [COORD_W-1:0]     rsp_out_x,
   output logic [COORD_W-1:0]     rsp_out_y,
   output logic                   rsp_last,

   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   logic [TAP_W-1:0]    tap_ff;

   // input register
   logic                in_valid_ff;
   logic [1:0]          act_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;

   logic [COORD_W-1:0]  x_in;
   logic [COORD_W-1:0]  y_in;
   logic                req_fire;
   logic                proc_fire;
   logic                load_ok;
   batch_type           batch;

   // Evaluate the held request once the result register can take its results.
   assign proc_fire = in_valid_ff && load_ok;
   assign req_ready = !reset && (!in_valid_ff || proc_fire);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         tap_ff    <= RESET_TAP;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_TAP_TIME:      tap_ff    <= csr_wdata[TAP_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Scale positions on the way into the input register.
   tgp_scale u_scale_x (
      .norm (req_norm_x),
      .size (width_ff),
      .pos  (x_in)
   );

   tgp_scale u_scale_y (
      .norm (req_norm_y),
      .size (height_ff),
      .pos  (y_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (proc_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Hold the request payload until it is evaluated.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_action;
         id_ff  <= req_finger_id;
         now_ff <= req_timestamp_ms;
         x_ff   <= x_in;
         y_ff   <= y_in;
      end
   end

   tgp_gesture #(
      .SLOTS (FINGER_SLOTS)
   ) u_gesture (
      .clock     (clock),
      .reset     (reset),
      .fire      (proc_fire),
      .action    (act_ff),
      .finger_id (id_ff),
      .now       (now_ff),
      .pos_x     (x_ff),
      .pos_y     (y_ff),
      .tap_time  (tap_ff),
      .batch     (batch)
   );

   tgp_outq u_outq (
      .clock          (clock),
      .reset          (reset),
      .load           (proc_fire),
      .batch          (batch),
      .load_ok        (load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_button     (rsp_button),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_last       (rsp_last)
   );

endmodule

>>> sv/tgp_checker.sv
// Port-level checks of the touch gesture to pointer block, bound to the top.
module tgp_checker
   import tgp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [1:0]          rsp_event_kind,
   input logic                rsp_button,
   input logic [COORD_W-1:0]  rsp_out_x,
   input logic [COORD_W-1:0]  rsp_out_y,
   input logic                rsp_last
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
         $stable(rsp_button) && $stable(rsp_out_x) && $stable(rsp_out_y) &&
         $stable(rsp_last))
      else $error("result changed while stalled");

   // results of one request leave without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a result burst");

   // a press that is not final is either a tap, released at once with the same
   // button at the same spot, or a drag start followed by a move
   a_tap_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_event_kind == EV_PRESS) && !rsp_last |=>
         (rsp_event_kind == EV_MOVE) ||
         ((rsp_event_kind == EV_RELEASE) && (rsp_button == $past(rsp_button)) &&
          (rsp_out_x == $past(rsp_out_x)) && (rsp_out_y == $past(rsp_out_y))))
      else $error("tap press without matching release");

   // a burst never starts with a release or a press
   a_burst_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=>
         !rsp_valid || (rsp_event_kind == EV_MOVE))
      else $error("result burst does not open with a move");

   // nothing leaves right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind touch_gesture_to_pointer tgp_checker u_tgp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_kind (rsp_event_kind),
   .rsp_button     (rsp_button),
   .rsp_out_x      (rsp_out_x),
   .rsp_out_y      (rsp_out_y),
   .rsp_last       (rsp_last)
);

>>> verif/tb.sv
// Testbench for touch_gesture_to_pointer: finger gestures in, checked pointer events out.
module tb;
   import tgp_pkg::*;

   localparam int          FINGERS      = 3;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          SETTLE_WAIT  = 8;
   // Action code the block must drop without a response.
   localparam logic [1:0]  ACT_RESERVED = 2'd3;

   // One expected pointer event, as it should leave the response channel.
   typedef struct {
      event_kind_type      kind;
      logic                button;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                last;
   } pointer_event_type;

   // Shadow of the finger table, drag mode and pointer; predicts and checks the
   // pointer events of every accepted touch transaction.
   class pointer_scoreboard;
      logic [SIZE_W-1:0]   width_q;
      logic [SIZE_W-1:0]   height_q;
      logic [TAP_W-1:0]    tap_q;
      bit                  used_q   [FINGERS];
      logic [ID_W-1:0]     id_q     [FINGERS];
      logic [TIME_W-1:0]   down_q   [FINGERS];
      logic [COORD_W-1:0]  fx_q     [FINGERS];
      logic [COORD_W-1:0]  fy_q     [FINGERS];
      logic [COORD_W-1:0]  lx_q     [FINGERS];
      logic [COORD_W-1:0]  ly_q     [FINGERS];
      drag_mode_type       mode_q;
      logic [COORD_W-1:0]  ptr_x;
      logic [COORD_W-1:0]  ptr_y;
      pointer_event_type   expected_q [$];
      int                  errors;

      function new();
         width_q  = RESET_WIDTH;
         height_q = RESET_HEIGHT;
         tap_q    = RESET_TAP;
         for (int i = 0; i < FINGERS; i++) begin
            used_q[i] = 1'b0;
            id_q[i]   = '0;
            down_q[i] = '0;
            fx_q[i]   = '0;
            fy_q[i]   = '0;
            lx_q[i]   = '0;
            ly_q[i]   = '0;
         end
         mode_q = DRAG_IDLE;
         ptr_x  = '0;
         ptr_y  = '0;
         errors = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] wdata);
         case (idx)
            CSR_SCREEN_WIDTH:  width_q  = wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_q = wdata[SIZE_W-1:0];
            CSR_TAP_TIME:      tap_q    = wdata[TAP_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Fixed-point scale to pixels, clamped to the 12-bit coordinate range.
      function logic [COORD_W-1:0] to_screen(input logic [NORM_W-1:0] norm,
                                             input logic [SIZE_W-1:0] size);
         logic [NORM_W+SIZE_W-1:0] prod;
         logic [SIZE_W-1:0]        whole;
         prod  = norm * size;
         whole = prod[NORM_W+SIZE_W-1:NORM_W];
         return whole[COORD_W] ? '1 : whole[COORD_W-1:0];
      endfunction

      // Wrapping test: has time t reached time u?
      function bit reached(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] u);
         logic [TIME_W-1:0] d;
         d = u - t;
         return (d == '0) || d[TIME_W-1];
      endfunction

      function int earliest();
         int                first;
         logic [TIME_W-1:0] early;
         first = -1;
         early = '0;
         for (int i = 0; i < FINGERS; i++) begin
            if (used_q[i] && (first < 0 || !reached(down_q[i], early))) begin
               first = i;
               early = down_q[i];
            end
         end
         return first;
      endfunction

      function void add_event(input event_kind_type kind, input logic btn,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
         pointer_event_type e;
         e.kind   = kind;
         e.button = btn;
         e.x      = x;
         e.y      = y;
         e.last   = 1'b0;
         expected_q.push_back(e);
         ptr_x = x;
         ptr_y = y;
      endfunction

      function void note_request(input logic [1:0] action, input logic [ID_W-1:0] fid,
                                 input logic [TIME_W-1:0] now,
                                 input logic [NORM_W-1:0] nx, input logic [NORM_W-1:0] ny);
         logic [COORD_W-1:0] x, y, sx, sy;
         int                 held, idx, slot, longs, f, first_n;
         logic               btn;
         drag_mode_type      prior;
         first_n = expected_q.size();
         x    = to_screen(nx, width_q);
         y    = to_screen(ny, height_q);
         held = 0;
         idx  = -1;
         slot = -1;
         for (int i = 0; i < FINGERS; i++) begin
            if (used_q[i]) begin
               if (id_q[i] == fid) idx = i;
               held++;
            end
            if (slot < 0 && (!used_q[i] || id_q[i] == fid)) slot = i;
         end
         case (action)
            ACT_DOWN: begin
               if (slot >= 0) begin
                  used_q[slot] = 1'b1;
                  id_q[slot]   = fid;
                  down_q[slot] = now;
                  fx_q[slot]   = x;
                  fy_q[slot]   = y;
                  lx_q[slot]   = x;
                  ly_q[slot]   = y;
                  if (held == 0) add_event(EV_MOVE, BTN_LEFT, x, y);
                  mode_q = DRAG_IDLE;
               end
            end
            ACT_UP: begin
               if (idx >= 0) begin
                  used_q[idx] = 1'b0;
                  if (mode_q == DRAG_IDLE) begin
                     if (!reached(now, down_q[idx] + tap_q) && held <= 2) begin
                        btn = (held == 2) ? BTN_RIGHT : BTN_LEFT;
                        if (btn == BTN_RIGHT) mode_q = DRAG_SPENT;
                        add_event(EV_MOVE, BTN_LEFT, x, y);
                        add_event(EV_PRESS, btn, x, y);
                        add_event(EV_RELEASE, btn, x, y);
                     end
                  end else if (held == 1) begin
                     prior  = mode_q;
                     sx     = ptr_x;
                     sy     = ptr_y;
                     mode_q = DRAG_IDLE;
                     if (prior == DRAG_TWO || prior == DRAG_THREE) begin
                        btn = (prior == DRAG_THREE) ? BTN_RIGHT : BTN_LEFT;
                        add_event(EV_MOVE, BTN_LEFT, sx, sy);
                        add_event(EV_RELEASE, btn, sx, sy);
                     end
                  end
               end
            end
            ACT_MOTION: begin
               if (idx >= 0) begin
                  if (held >= 2 && mode_q == DRAG_IDLE) begin
                     longs = 0;
                     for (int i = 0; i < FINGERS; i++)
                        if (used_q[i] && reached(now, down_q[i] + tap_q)) longs++;
                     if (longs >= 2) begin
                        f = earliest();
                        if (f < 0) f = idx;
                        btn    = (longs == 2) ? BTN_LEFT : BTN_RIGHT;
                        mode_q = (longs == 2) ? DRAG_TWO : DRAG_THREE;
                        add_event(EV_MOVE, BTN_LEFT, fx_q[f], fy_q[f]);
                        add_event(EV_PRESS, btn, fx_q[f], fy_q[f]);
                     end
                  end
                  if (x != lx_q[idx] || y != ly_q[idx]) begin
                     lx_q[idx] = x;
                     ly_q[idx] = y;
                     if (held <= 1 || earliest() == idx) add_event(EV_MOVE, BTN_LEFT, x, y);
                  end
               end
            end
            default: ;
         endcase
         if (expected_q.size() > first_n) expected_q[expected_q.size()-1].last = 1'b1;
      endfunction

      function void check_result(input logic [1:0] kind, input logic btn,
                                 input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic last);
         pointer_event_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected pointer event: event_kind %0d x %0d y %0d", kind, x, y);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (kind !== e.kind) begin
            $error("event_kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (btn !== e.button) begin
            $error("button: expected %0d, actual %0d", e.button, btn);
            errors++;
         end
         if (x !== e.x) begin
            $error("out_x: expected %0d, actual %0d", e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $error("out_y: expected %0d, actual %0d", e.y, y);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last);
            errors++;
         end
      endfunction
   endclass

   // DUT ports; every input starts at a known value.
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_action       = '0;
   logic [ID_W-1:0]        req_finger_id    = '0;
   logic [TIME_W-1:0]      req_timestamp_ms = '0;
   logic [NORM_W-1:0]      req_norm_x       = '0;
   logic [NORM_W-1:0]      req_norm_y       = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [1:0]             rsp_event_kind;
   logic                   rsp_button;
   logic [COORD_W-1:0]     rsp_out_x;
   logic [COORD_W-1:0]     rsp_out_y;
   logic                   rsp_last;
   logic                   csr_write        = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   pointer_scoreboard sb = new;

   // Stimulus state: idle and stall rates in percent, panel clock, tap time.
   int                send_idle   = 0;
   int                recv_stall  = 0;
   int                counted     = 0;
   int                cycle_count = 0;
   int                tap_cur     = 250;
   logic [TIME_W-1:0] now_ms;
   logic [TIME_W-1:0] t0;
   int                w_set, h_set, t_set, target;
   bit                paused;

   touch_gesture_to_pointer u_top (.*);

   always #4 clock = ~clock;

   // Hard stop in case the block hangs or loses a response.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Receiver: decide readiness on the falling edge, check on the rising edge.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_event_kind, rsp_button, rsp_out_x, rsp_out_y, rsp_last);

   // Present one touch transaction, hold it until accepted, then record it.
   task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] fid,
                            input logic [TIME_W-1:0] ts,
                            input logic [NORM_W-1:0] nx, input logic [NORM_W-1:0] ny);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_finger_id    <= fid;
      req_timestamp_ms <= ts;
      req_norm_x       <= nx;
      req_norm_y       <= ny;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(act, fid, ts, nx, ny);
   endtask

   // Drop valid and wait until every predicted event has come out, then let
   // any request without a response finish inside the block.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      sb.set_reg(idx, wdata);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // One well-formed gesture: fingers down, a hold (short or past the tap
   // time), up to four motions, then every finger up in a rotated order, forward or backward.
   task automatic run_gesture();
      int                nf, nm, k, start, dir;
      logic [ID_W-1:0]   ids [4];
      logic [NORM_W-1:0] gx  [4];
      logic [NORM_W-1:0] gy  [4];
      nf = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) nf = 4;
      // Keep ids distinct inside a gesture so each up matches only its own finger.
      ids[0] = $urandom_range(0, 255);
      for (int i = 1; i < 4; i++) ids[i] = ids[i-1] + 8'($urandom_range(1, 60));
      for (int i = 0; i < nf; i++) begin
         gx[i] = 16'($urandom);
         gy[i] = 16'($urandom);
         send_item(ACT_DOWN, ids[i], now_ms, gx[i], gy[i]);
         now_ms += $urandom_range(0, 40);
      end
      if ($urandom_range(0, 1)) now_ms += $urandom_range(0, tap_cur / 2);
      else                      now_ms += tap_cur + $urandom_range(1, 300);
      nm = $urandom_range(0, 4);
      for (int i = 0; i < nm; i++) begin
         k = $urandom_range(0, nf - 1);
         // Mostly move; sometimes repeat the finger's last position.
         if ($urandom_range(0, 3) != 0) begin
            gx[k] = 16'($urandom);
            gy[k] = 16'($urandom);
         end
         send_item(ACT_MOTION, ids[k], now_ms, gx[k], gy[k]);
         now_ms += $urandom_range(0, 60);
      end
      start = $urandom_range(0, nf - 1);
      dir   = $urandom_range(0, 1) ? 1 : nf - 1;
      for (int i = 0; i < nf; i++) begin
         k = (start + i * dir) % nf;
         send_item(ACT_UP, ids[k], now_ms, 16'($urandom), 16'($urandom));
         now_ms += $urandom_range(0, 60);
      end
      counted += 2 * nf + nm;
   endtask

   // Broken sequences on a small id pool (reserved actions, stray ups and
   // motions, duplicate downs, time jumps), then lift the pool clean.
   task automatic send_noise();
      int                n;
      logic [TIME_W-1:0] ts;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         ts = ($urandom_range(0, 7) == 0) ? $urandom : now_ms;
         now_ms += $urandom_range(0, 300);
         send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), ts,
                   16'($urandom), 16'($urandom));
      end
      // Twice per id: a duplicated id may sit in two slots.
      for (int i = 0; i < 8; i++)
         send_item(ACT_UP, 8'(i % 4), now_ms, 16'($urandom), 16'($urandom));
      counted += n + 8;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part at the reset setting, starting just before the panel
      // clock wraps, so the first tap lies before the wrap and the later gestures after it.
      t0 = 32'hFFFF_FF00;
      // Single tap, with a motion that does not change the position first.
      send_item(ACT_DOWN,   8'h00, t0,          16'h0000, 16'h0000);
      send_item(ACT_MOTION, 8'h00, t0 + 32'd1,  16'h0000, 16'h0000);
      send_item(ACT_MOTION, 8'h00, t0 + 32'd2,  16'hFFFF, 16'hFFFF);
      send_item(ACT_UP,     8'h00, t0 + 32'd10, 16'hFFFF, 16'hFFFF);
      // Reserved action and a finger nobody holds: both dropped.
      send_item(ACT_RESERVED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_UP,       8'hFF, t0 + 32'd20,   16'h1234, 16'h4321);
      // Second-finger tap gives a right click, then the drag-over release.
      send_item(ACT_DOWN, 8'h01, t0 + 32'd300, 16'h8000, 16'h8000);
      send_item(ACT_DOWN, 8'h02, t0 + 32'd305, 16'h4000, 16'h4000);
      send_item(ACT_UP,   8'h02, t0 + 32'd320, 16'h4000, 16'h4000);
      send_item(ACT_UP,   8'h01, t0 + 32'd330, 16'h8000, 16'h8000);
      // Two fingers held long: left drag.
      send_item(ACT_DOWN,   8'hAA, t0 + 32'd400, 16'h1234, 16'h5678);
      send_item(ACT_DOWN,   8'h55, t0 + 32'd410, 16'hFEDC, 16'hBA98);
      send_item(ACT_MOTION, 8'hAA, t0 + 32'd700, 16'h2000, 16'h3000);
      send_item(ACT_UP,     8'h55, t0 + 32'd710, 16'h0001, 16'h0001);
      send_item(ACT_UP,     8'hAA, t0 + 32'd720, 16'h0002, 16'h0002);
      // Three fingers held long: right drag; a fourth finger finds no slot.
      send_item(ACT_DOWN,   8'h03, t0 + 32'd800,  16'h7000, 16'h0700);
      send_item(ACT_DOWN,   8'h04, t0 + 32'd805,  16'h0800, 16'h8000);
      send_item(ACT_DOWN,   8'h05, t0 + 32'd810,  16'h9000, 16'h0900);
      send_item(ACT_DOWN,   8'h06, t0 + 32'd815,  16'hA000, 16'hA000);
      send_item(ACT_MOTION, 8'h04, t0 + 32'd1200, 16'h1111, 16'h2222);
      send_item(ACT_UP,     8'h03, t0 + 32'd1210, 16'h0000, 16'h0000);
      send_item(ACT_UP,     8'h05, t0 + 32'd1220, 16'h0000, 16'h0000);
      send_item(ACT_UP,     8'h04, t0 + 32'd1230, 16'h0000, 16'h0000);
      // Tap with three fingers down emits nothing.
      send_item(ACT_DOWN, 8'h07, t0 + 32'd1300, 16'h3000, 16'h3000);
      send_item(ACT_DOWN, 8'h08, t0 + 32'd1305, 16'h5000, 16'h5000);
      send_item(ACT_DOWN, 8'h09, t0 + 32'd1310, 16'h6000, 16'h6000);
      send_item(ACT_UP,   8'h08, t0 + 32'd1320, 16'h5000, 16'h5000);
      send_item(ACT_UP,   8'h07, t0 + 32'd1330, 16'h3000, 16'h3000);
      send_item(ACT_UP,   8'h09, t0 + 32'd1340, 16'h6000, 16'h6000);

      // Random phases: each starts idle with a new setting and idle pattern.
      now_ms = $urandom;
      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin w_set = 640;  h_set = 480;  t_set = 250;   end
            1: begin w_set = 4096; h_set = 4096; t_set = 0;     end
            2: begin w_set = 1;    h_set = 1;    t_set = 65535; end
            // Wider than the coordinate range: x clamps.
            3: begin w_set = 8191; h_set = 4096; t_set = 100;   end
            default: begin
               w_set = $urandom_range(1, 4096);
               h_set = $urandom_range(1, 4096);
               t_set = $urandom_range(30, 600);
            end
         endcase
         write_reg(CSR_SCREEN_WIDTH,  16'(w_set));
         write_reg(CSR_SCREEN_HEIGHT, 16'(h_set));
         write_reg(CSR_TAP_TIME,      16'(t_set));
         tap_cur = t_set;
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 73; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 73; end
            default: begin send_idle = 19; recv_stall = 19; end
         endcase
         target  = counted + 31;
         paused  = 1'b0;
         while (counted < target) begin
            if ($urandom_range(0, 9) < 8) run_gesture();
            else                          send_noise();
            // Halfway through, hold off until the block has drained.
            if (!paused && counted >= target - 15) begin
               settle();
               paused = 1'b1;
            end
         end
      end

      settle();
      if (sb.errors == 0) $display("tb: clean");
      else                $display("tb: errors");
      $finish;
   end

endmodule
